FILE: hdl/msq_pkg.sv
package msq_pkg;

    // Command codes on the input channel
    localparam logic [2:0] CMD_BEGIN = 3'd0;
    localparam logic [2:0] CMD_LOAD  = 3'd1;
    localparam logic [2:0] CMD_PLAY  = 3'd2;
    localparam logic [2:0] CMD_CHIRP = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // Sound actions on the output channel
    localparam logic ACTION_TONE    = 1'b0;
    localparam logic ACTION_SILENCE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_MIN_TONE_FREQ      = 2'd0;
    localparam logic [1:0] REG_ACK_FREQ           = 2'd1;
    localparam logic [1:0] REG_ACK_LENGTH_MS      = 2'd2;
    localparam logic [1:0] REG_SELFTEST_LENGTH_MS = 2'd3;

    localparam logic [15:0] MIN_TONE_FREQ_RST      = 16'd8000;
    localparam logic [15:0] ACK_FREQ_RST           = 16'd9000;
    localparam logic [15:0] ACK_LENGTH_MS_RST      = 16'd12;
    localparam logic [15:0] SELFTEST_LENGTH_MS_RST = 16'd30;

    // Request queue between the classifier and the executor
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_LOAD,
        OP_PLAY,
        OP_CHIRP,
        OP_TICK
    } op_t;

    typedef struct packed {
        logic [15:0] min_tone_freq;
        logic [15:0] ack_freq;
        logic [15:0] ack_length_ms;
        logic [15:0] selftest_length_ms;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [3:0]  note_slot;
        logic [15:0] note_freq;
        logic [15:0] note_length;
        logic [7:0]  note_count;
        logic [31:0] now_ms;
    } q_item_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] length;
    } note_t;

endpackage

FILE: hdl/msq_if.sv
interface msq_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [3:0]  note_slot;
    logic [15:0] note_freq;
    logic [15:0] note_length;
    logic [7:0]  note_count;
    logic [31:0] now_ms;

    modport source (
        output valid, command, note_slot, note_freq, note_length, note_count, now_ms,
        input  ready
    );
    modport sink (
        input  valid, command, note_slot, note_freq, note_length, note_count, now_ms,
        output ready
    );
endinterface

interface msq_snd_if;
    logic        valid;
    logic        ready;
    logic        sound_action;
    logic [15:0] tone_freq;
    logic [15:0] tone_length;
    logic        melody_active;

    modport source (
        output valid, sound_action, tone_freq, tone_length, melody_active,
        input  ready
    );
    modport sink (
        input  valid, sound_action, tone_freq, tone_length, melody_active,
        output ready
    );
endinterface

FILE: hdl/msq_front.sv
module msq_front #(
    parameter int MAX_NOTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    msq_cmd_if.sink           cmd,
    input  logic              q_full,
    output logic              q_push,
    output msq_pkg::q_item_t  q_item
);
    import msq_pkg::*;

    logic started_reg;
    logic started_next;
    logic keep;
    logic accept;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign q_push    = accept && keep;

    // Classify: drop what can never give a result or change the store
    always_comb
    begin
        keep         = 1'b0;
        started_next = started_reg;
        q_item.op          = OP_TICK;
        q_item.note_slot   = cmd.note_slot;
        q_item.note_freq   = cmd.note_freq;
        q_item.note_length = cmd.note_length;
        q_item.note_count  = cmd.note_count;
        q_item.now_ms      = cmd.now_ms;
        case (cmd.command)
            CMD_BEGIN:
            begin
                q_item.op = OP_BEGIN;
                keep      = !started_reg;
                if (accept)
                begin
                    started_next = 1'b1;
                end
            end
            CMD_LOAD:
            begin
                q_item.op = OP_LOAD;
                keep      = {4'd0, cmd.note_slot} < 8'(MAX_NOTES);
            end
            CMD_PLAY:
            begin
                q_item.op = OP_PLAY;
                keep      = started_reg && (cmd.note_count != 8'd0);
                if (cmd.note_count > 8'(MAX_NOTES))
                begin
                    q_item.note_count = 8'(MAX_NOTES);
                end
            end
            CMD_CHIRP:
            begin
                q_item.op = OP_CHIRP;
                keep      = started_reg;
            end
            CMD_TICK:
            begin
                q_item.op = OP_TICK;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
        end
    end

endmodule

FILE: hdl/msq_queue.sv
module msq_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  msq_pkg::q_item_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output msq_pkg::q_item_t  head
);
    import msq_pkg::*;

    q_item_t              slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign valid = count_reg != '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("request queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n) (pop && !push) |=> !full)
        else $error("request queue full after a lone pop");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !valid))
        else $error("request queue popped while empty");

endmodule

FILE: hdl/msq_back.sv
module msq_back #(
    parameter int MAX_NOTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  msq_pkg::cfg_t     cfg,
    input  logic              q_valid,
    input  msq_pkg::q_item_t  q_head,
    output logic              q_pop,
    msq_snd_if.source         snd
);
    import msq_pkg::*;

    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

    typedef enum logic [1:0] {
        ST_EXEC = 2'b01,
        ST_NOTE = 2'b10
    } state_t;

    state_t       state_reg,  state_next;
    logic         playing_reg, playing_next;
    logic [7:0]   length_reg, length_next;
    logic [7:0]   index_reg,  index_next;
    logic [31:0]  deadline_reg, deadline_next;
    logic [31:0]  note_now_reg, note_now_next;

    note_t        store [MAX_NOTES];
    note_t        rd_note_reg;
    logic         mem_we;
    logic         mem_re;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    logic         out_valid_reg;
    logic         out_action_reg;
    logic [15:0]  out_freq_reg;
    logic [15:0]  out_length_reg;
    logic         out_active_reg;
    logic         out_load;
    logic         out_action_d;
    logic [15:0]  out_freq_d;
    logic [15:0]  out_length_d;
    logic         out_active_d;
    logic         out_free;

    logic [31:0]  tick_diff;
    logic [7:0]   index_inc;
    logic [15:0]  fixed_length;

    assign out_free  = !out_valid_reg || snd.ready;
    assign q_pop     = (state_reg == ST_EXEC) && q_valid && out_free;
    assign tick_diff = q_head.now_ms - deadline_reg;
    assign index_inc = index_reg + 8'd1;
    assign wr_addr   = AW'(q_head.note_slot);
    assign fixed_length = (rd_note_reg.length == 16'd0) ? 16'd1 : rd_note_reg.length;

    always_comb
    begin
        state_next    = state_reg;
        playing_next  = playing_reg;
        length_next   = length_reg;
        index_next    = index_reg;
        deadline_next = deadline_reg;
        note_now_next = note_now_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_addr       = AW'(index_reg);
        out_load      = 1'b0;
        out_action_d  = ACTION_SILENCE;
        out_freq_d    = 16'd0;
        out_length_d  = 16'd0;
        out_active_d  = 1'b0;
        case (state_reg)
            ST_EXEC:
            begin
                if (q_pop)
                begin
                    case (q_head.op)
                        OP_BEGIN:
                        begin
                            out_load     = 1'b1;
                            out_action_d = ACTION_TONE;
                            out_freq_d   = cfg.ack_freq;
                            out_length_d = cfg.selftest_length_ms;
                            out_active_d = playing_reg;
                        end
                        OP_LOAD:
                        begin
                            mem_we = 1'b1;
                        end
                        OP_PLAY:
                        begin
                            playing_next  = 1'b1;
                            length_next   = q_head.note_count;
                            index_next    = 8'd0;
                            mem_re        = 1'b1;
                            rd_addr       = '0;
                            note_now_next = q_head.now_ms;
                            state_next    = ST_NOTE;
                        end
                        OP_CHIRP:
                        begin
                            playing_next = 1'b0;
                            length_next  = 8'd0;
                            index_next   = 8'd0;
                            out_load     = 1'b1;
                            out_action_d = ACTION_TONE;
                            out_freq_d   = cfg.ack_freq;
                            out_length_d = cfg.ack_length_ms;
                            out_active_d = 1'b0;
                        end
                        OP_TICK:
                        begin
                            if (playing_reg && !tick_diff[31])
                            begin
                                if (index_inc >= length_reg)
                                begin
                                    playing_next = 1'b0;
                                    length_next  = 8'd0;
                                    index_next   = 8'd0;
                                    out_load     = 1'b1;
                                end
                                else
                                begin
                                    index_next    = index_inc;
                                    mem_re        = 1'b1;
                                    rd_addr       = AW'(index_inc);
                                    note_now_next = q_head.now_ms;
                                    state_next    = ST_NOTE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NOTE:
            begin
                // Store data is in; set the deadline and sound the note
                if (out_free)
                begin
                    deadline_next = note_now_reg + 32'(fixed_length);
                    out_load      = 1'b1;
                    out_active_d  = 1'b1;
                    if (rd_note_reg.freq >= cfg.min_tone_freq)
                    begin
                        out_action_d = ACTION_TONE;
                        out_freq_d   = rd_note_reg.freq;
                        out_length_d = fixed_length;
                    end
                    state_next = ST_EXEC;
                end
            end
            default:
            begin
                state_next = ST_EXEC;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[wr_addr] <= '{freq: q_head.note_freq, length: q_head.note_length};
        end
        if (mem_re)
        begin
            rd_note_reg <= store[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_action_reg <= out_action_d;
            out_freq_reg   <= out_freq_d;
            out_length_reg <= out_length_d;
            out_active_reg <= out_active_d;
        end
        note_now_reg <= note_now_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_EXEC;
            playing_reg   <= 1'b0;
            length_reg    <= 8'd0;
            index_reg     <= 8'd0;
            deadline_reg  <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            playing_reg  <= playing_next;
            length_reg   <= length_next;
            index_reg    <= index_next;
            deadline_reg <= deadline_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (snd.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign snd.valid         = out_valid_reg;
    assign snd.sound_action  = out_action_reg;
    assign snd.tone_freq     = out_freq_reg;
    assign snd.tone_length   = out_length_reg;
    assign snd.melody_active = out_active_reg;

    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_NOTE) |-> playing_reg)
        else $error("note fetch without a running melody");

    assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> (index_reg < length_reg))
        else $error("note index past melody length");

    assert property (@(posedge clk) disable iff (!rst_n) length_reg <= 8'(MAX_NOTES))
        else $error("melody length beyond store size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !snd.ready) |-> !out_load)
        else $error("result overwritten while stalled");

endmodule

FILE: hdl/melody_note_sequencer_top.sv
// Channel | Dir | Payload                                            | Handshake
// cmd     | in  | command, note_slot, note_freq, note_length,        | valid/ready
//         |     | note_count, now_ms                                 |
// snd     | out | sound_action, tone_freq, tone_length, melody_active| valid/ready
// cfg     | in  | cfg_write_en, cfg_index, cfg_data (16 bits)        | write only
//
// One request is taken per cycle while the two-entry request queue has room.
// Begin, load, chirp and a tick that ends or holds the melody finish in the executor
// state; play and a tick that starts the next note also pass through the note state,
// for the registered read of the note store (fetch, then deadline and result).
// Reset clears control state only; note store entries are undefined until loaded.
// A stalled snd channel holds the result register and stops the executor; the
// queue then fills and cmd ready drops.
module melody_note_sequencer_top #(
    parameter int MAX_NOTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    msq_cmd_if.sink     cmd,
    msq_snd_if.source   snd,
    input  logic        cfg_write_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import msq_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    q_item_t q_in;
    q_item_t q_head;

    // Configuration registers; written only while the block is idle (the user's rule; the block does not enforce it)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_tone_freq      <= MIN_TONE_FREQ_RST;
            cfg_reg.ack_freq           <= ACK_FREQ_RST;
            cfg_reg.ack_length_ms      <= ACK_LENGTH_MS_RST;
            cfg_reg.selftest_length_ms <= SELFTEST_LENGTH_MS_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_MIN_TONE_FREQ:      cfg_reg.min_tone_freq      <= cfg_data;
                REG_ACK_FREQ:           cfg_reg.ack_freq           <= cfg_data;
                REG_ACK_LENGTH_MS:      cfg_reg.ack_length_ms      <= cfg_data;
                REG_SELFTEST_LENGTH_MS: cfg_reg.selftest_length_ms <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Front: accept and classify requests, track the started flag
    msq_front #(
        .MAX_NOTES (MAX_NOTES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    // Decouple the classifier from the executor
    msq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Back: note store, melody player and result register
    msq_back #(
        .MAX_NOTES (MAX_NOTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .snd     (snd)
    );

endmodule

FILE: bench/melody_note_sequencer_top_tb.sv
`timescale 1ns / 100ps

module melody_note_sequencer_top_tb;

    import msq_pkg::*;

    localparam int NOTE_SLOTS   = 16;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 206;
    localparam int TAIL_ITEMS   = 150;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 400;

    // Command codes the block must drop without a result
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    // One request on the command channel
    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  slot;
        logic [15:0] freq;
        logic [15:0] length;
        logic [7:0]  count;
        logic [31:0] now;
    } req_t;

    // One result on the sound channel
    typedef struct packed {
        logic        action;
        logic [15:0] freq;
        logic [15:0] length;
        logic        active;
    } snd_t;

    // Directed row: a request plus, where obvious, the sound it must give
    typedef struct packed {
        req_t req;
        bit   typed;
        snd_t want;
    } row_t;

    localparam snd_t UNTYPED = '0;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    msq_cmd_if cmd_bus ();
    msq_snd_if snd_bus ();

    melody_note_sequencer_top #(
        .MAX_NOTES (NOTE_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_bus),
        .snd          (snd_bus),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Shadow copy of the configuration registers
    logic [15:0] floor_hz    = MIN_TONE_FREQ_RST;
    logic [15:0] ack_hz      = ACK_FREQ_RST;
    logic [15:0] ack_ms      = ACK_LENGTH_MS_RST;
    logic [15:0] selftest_ms = SELFTEST_LENGTH_MS_RST;

    // Shadow copy of the sequencer state
    bit          seq_started  = 1'b0;
    bit          seq_playing  = 1'b0;
    logic [7:0]  seq_count    = 8'd0;
    logic [7:0]  seq_index    = 8'd0;
    logic [31:0] seq_deadline = 32'd0;
    logic [15:0] slot_freq [NOTE_SLOTS];
    logic [15:0] slot_len  [NOTE_SLOTS];
    bit          slot_loaded [NOTE_SLOTS];

    // Sounds predicted but not yet seen on the output channel
    snd_t        pending_sounds [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    // Idle control for both sides; the tail of the run drops all idling
    int unsigned sender_idle_pct = 0;
    bit          quiet_tail      = 1'b0;

    // Directed opening: reset defaults, ignored requests, wrap of the deadline
    row_t opening_rows [23] = '{
        // Tick while idle, play and chirp before begin: all dropped
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        '{'{CMD_PLAY,  4'h0, 16'h0000, 16'h0000, 8'd3,   32'h0000_0064}, 1'b0, UNTYPED},
        '{'{CMD_CHIRP, 4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        '{'{CMD_UNUSED_LO, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b0, UNTYPED},
        // First begin gives the self-test tone; a second begin is silent
        '{'{CMD_BEGIN, 4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b1,
          '{ACTION_TONE, ACK_FREQ_RST, SELFTEST_LENGTH_MS_RST, 1'b0}},
        '{'{CMD_BEGIN, 4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        '{'{CMD_UNUSED_HI, 4'h0, 16'h0000, 16'h0000, 8'd0, 32'h0000_0000}, 1'b0, UNTYPED},
        // Fill slots 0..3: top frequency with zero length, rest, just below
        // and exactly at the floor
        '{'{CMD_LOAD,  4'h0, 16'hFFFF, 16'h0000, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        '{'{CMD_LOAD,  4'h1, 16'h0000, 16'hFFFF, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        '{'{CMD_LOAD,  4'h2, 16'd7999, 16'd5,    8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        '{'{CMD_LOAD,  4'h3, 16'd8000, 16'd1,    8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        // Zero count is dropped
        '{'{CMD_PLAY,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED},
        // Play at the top of time: zero length becomes 1 ms, deadline wraps to 0
        '{'{CMD_PLAY,  4'h0, 16'h0000, 16'h0000, 8'd4,   32'hFFFF_FFFF}, 1'b1,
          '{ACTION_TONE, 16'hFFFF, 16'd1, 1'b1}},
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'hFFFF_FFFE}, 1'b0, UNTYPED},
        // Rest plays as silence
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b1,
          '{ACTION_SILENCE, 16'd0, 16'd0, 1'b1}},
        // Difference of exactly 2^31 reads as negative: hold
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h8000_FFFF}, 1'b0, UNTYPED},
        // Largest positive difference: advance; one below the floor is silence
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h8000_FFFE}, 1'b1,
          '{ACTION_SILENCE, 16'd0, 16'd0, 1'b1}},
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h8001_0003}, 1'b1,
          '{ACTION_TONE, 16'd8000, 16'd1, 1'b1}},
        // Past the last note: stop
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'h8001_0004}, 1'b1,
          '{ACTION_SILENCE, 16'd0, 16'd0, 1'b0}},
        '{'{CMD_TICK,  4'h0, 16'h0000, 16'h0000, 8'd0,   32'hFFFF_FFFF}, 1'b0, UNTYPED},
        // Chirp cancels a running melody
        '{'{CMD_PLAY,  4'h0, 16'h0000, 16'h0000, 8'd2,   32'h1234_5678}, 1'b0, UNTYPED},
        '{'{CMD_CHIRP, 4'h0, 16'h0000, 16'h0000, 8'd0,   32'h0000_0000}, 1'b1,
          '{ACTION_TONE, ACK_FREQ_RST, ACK_LENGTH_MS_RST, 1'b0}},
        '{'{CMD_LOAD,  4'hF, 16'h5A5A, 16'hA5A5, 8'd0,   32'h0000_0000}, 1'b0, UNTYPED}
    };

    // Clear the melody registers
    function automatic void drop_melody();
        seq_playing  = 1'b0;
        seq_count    = 8'd0;
        seq_index    = 8'd0;
        seq_deadline = 32'd0;
    endfunction

    // Sound the note at the current index and arm its deadline
    function automatic snd_t start_note(input logic [31:0] now);
        logic [15:0] f;
        logic [15:0] d;
        f = slot_freq[seq_index[3:0]];
        d = slot_len[seq_index[3:0]];
        if (d == 16'd0)
            d = 16'd1;
        seq_deadline = now + {16'd0, d};
        if (f >= floor_hz)
            return '{ACTION_TONE, f, d, seq_playing};
        return '{ACTION_SILENCE, 16'd0, 16'd0, seq_playing};
    endfunction

    // Advance the shadow sequencer by one request; return 1 when it sounds
    function automatic bit step_sequencer(input req_t r, output snd_t s);
        logic [7:0]  count;
        logic [31:0] late;
        s = '0;
        case (r.command)
            CMD_BEGIN:
            begin
                if (seq_started)
                    return 1'b0;
                seq_started = 1'b1;
                s = '{ACTION_TONE, ack_hz, selftest_ms, seq_playing};
                return 1'b1;
            end
            CMD_LOAD:
            begin
                slot_freq[r.slot] = r.freq;
                slot_len[r.slot]  = r.length;
                return 1'b0;
            end
            CMD_PLAY:
            begin
                if (!seq_started || r.count == 8'd0)
                    return 1'b0;
                count = (r.count > NOTE_SLOTS) ? 8'(NOTE_SLOTS) : r.count;
                drop_melody();
                seq_playing = 1'b1;
                seq_count   = count;
                s = start_note(r.now);
                return 1'b1;
            end
            CMD_CHIRP:
            begin
                if (!seq_started)
                    return 1'b0;
                drop_melody();
                s = '{ACTION_TONE, ack_hz, ack_ms, 1'b0};
                return 1'b1;
            end
            CMD_TICK:
            begin
                if (!seq_playing)
                    return 1'b0;
                // Signed distance to the deadline, safe across the wrap
                late = r.now - seq_deadline;
                if (late[31])
                    return 1'b0;
                seq_index = seq_index + 8'd1;
                if (seq_index >= seq_count)
                begin
                    drop_melody();
                    s = '{ACTION_SILENCE, 16'd0, 16'd0, 1'b0};
                    return 1'b1;
                end
                s = start_note(r.now);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Number of slots loaded in a row from slot 0: the longest safe melody
    function automatic int loaded_run();
        int n;
        n = 0;
        while (n < NOTE_SLOTS && slot_loaded[n])
            n++;
        return n;
    endfunction

    // Draw one random request; mostly well-formed melody traffic, some noise
    function automatic req_t make_request();
        req_t r;
        int   pick;
        int   run;
        r.command = CMD_TICK;
        r.slot    = 4'($urandom);
        r.freq    = 16'($urandom);
        r.length  = 16'($urandom);
        r.count   = 8'($urandom);
        r.now     = $urandom;
        pick = $urandom_range(0, 99);
        run  = loaded_run();
        if (pick < 15)
        begin
            r.command = CMD_LOAD;
            case ($urandom_range(0, 5))
                0: r.freq = 16'd0;
                1: r.freq = 16'hFFFF;
                2: r.freq = floor_hz;
                3: r.freq = floor_hz - 16'd1;
                default: ;
            endcase
            case ($urandom_range(0, 5))
                0: r.length = 16'd0;
                1: r.length = 16'hFFFF;
                2, 3: r.length = 16'($urandom_range(0, 50));
                default: ;
            endcase
        end
        else if (pick < 27)
        begin
            r.command = CMD_PLAY;
            // Never start a melody that would reach an unloaded slot
            if (run == NOTE_SLOTS)
            begin
                case ($urandom_range(0, 5))
                    0: r.count = 8'd0;
                    1: r.count = 8'($urandom_range(NOTE_SLOTS + 1, 255));
                    2: r.count = 8'hFF;
                    default: r.count = 8'($urandom_range(1, NOTE_SLOTS));
                endcase
            end
            else if (run == 0 || $urandom_range(0, 7) == 0)
                r.count = 8'd0;
            else
                r.count = 8'($urandom_range(1, run));
        end
        else if (pick < 32)
            r.command = CMD_CHIRP;
        else if (pick < 35)
            r.command = CMD_BEGIN;
        else if (pick < 40)
            r.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else if (seq_playing)
        begin
            // Aim ticks around the deadline so notes actually advance
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: r.now = seq_deadline + $urandom_range(0, 3);
                6, 7: r.now = seq_deadline - $urandom_range(1, 4);
                8: r.now = seq_deadline + ($urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                  : 32'h8000_0000);
                default: ;
            endcase
        end
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then predict its sound
    task automatic push_request(input req_t r, input bit typed, input snd_t want);
        snd_t s;
        bit   sounds;
        if (!quiet_tail && $urandom_range(0, 99) < sender_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.command     <= r.command;
        cmd_bus.note_slot   <= r.slot;
        cmd_bus.note_freq   <= r.freq;
        cmd_bus.note_length <= r.length;
        cmd_bus.note_count  <= r.count;
        cmd_bus.now_ms      <= r.now;
        do
            @(posedge clk);
        while (cmd_bus.ready !== 1'b1);
        sounds = step_sequencer(r, s);
        if (r.command == CMD_LOAD)
            slot_loaded[r.slot] = 1'b1;
        if (typed)
            pending_sounds.push_back(want);
        else if (sounds)
            pending_sounds.push_back(s);
    endtask

    // Hold off requests until every predicted sound is out and the block is idle
    task automatic drain_sounds();
        cmd_bus.valid <= 1'b0;
        while (pending_sounds.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register and track it in the shadow copy
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        case (idx)
            REG_MIN_TONE_FREQ:      floor_hz    = value;
            REG_ACK_FREQ:           ack_hz      = value;
            REG_ACK_LENGTH_MS:      ack_ms      = value;
            REG_SELFTEST_LENGTH_MS: selftest_ms = value;
            default: ;
        endcase
    endtask

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Sound channel ready: random stall bursts, then solid ready in the tail
    initial
    begin
        int n;
        int spell;
        int stall_pct;
        spell     = 0;
        stall_pct = 0;
        forever
        begin
            if (spell == 0)
            begin
                spell = $urandom_range(10, 40);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 60;
                endcase
            end
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct)
            begin
                snd_bus.ready <= 1'b0;
                n = $urandom_range(1, 9);
            end
            else
            begin
                snd_bus.ready <= 1'b1;
                n = $urandom_range(1, 6);
            end
            repeat (n) @(posedge clk);
            spell--;
        end
    end

    // Check every sound that leaves the block against the oldest prediction
    always @(posedge clk)
    begin
        snd_t want;
        if (rst_n && snd_bus.valid === 1'b1 && snd_bus.ready === 1'b1)
        begin
            if (pending_sounds.size() == 0)
            begin
                $error("unexpected sound: action %0d freq %0d length %0d active %0d",
                       snd_bus.sound_action, snd_bus.tone_freq, snd_bus.tone_length,
                       snd_bus.melody_active);
                mismatch_count++;
            end
            else
            begin
                want = pending_sounds.pop_front();
                if (snd_bus.sound_action !== want.action)
                begin
                    $error("sound_action: expected %0d, got %0d", want.action,
                           snd_bus.sound_action);
                    mismatch_count++;
                end
                if (snd_bus.tone_freq !== want.freq)
                begin
                    $error("tone_freq: expected %0d, got %0d", want.freq, snd_bus.tone_freq);
                    mismatch_count++;
                end
                if (snd_bus.tone_length !== want.length)
                begin
                    $error("tone_length: expected %0d, got %0d", want.length,
                           snd_bus.tone_length);
                    mismatch_count++;
                end
                if (snd_bus.melody_active !== want.active)
                begin
                    $error("melody_active: expected %0d, got %0d", want.active,
                           snd_bus.melody_active);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) ||
            (snd_bus.valid === 1'b1 && snd_bus.ready === 1'b1) || cfg_write_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Main sequence: reset, directed opening, then randomized phases
    initial
    begin
        logic [15:0] phase_regs [PHASES][4];
        int          ph;
        int          k;

        // Extremes first, then the reset values, then two random settings
        phase_regs[0] = '{16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_regs[1] = '{16'hFFFF, 16'd0, 16'd1, 16'd1};
        phase_regs[2] = '{MIN_TONE_FREQ_RST, ACK_FREQ_RST, ACK_LENGTH_MS_RST,
                          SELFTEST_LENGTH_MS_RST};
        for (ph = 3; ph < PHASES; ph++)
        begin
            phase_regs[ph][0] = 16'($urandom);
            phase_regs[ph][1] = 16'($urandom);
            phase_regs[ph][2] = 16'($urandom_range(1, 65535));
            phase_regs[ph][3] = 16'($urandom_range(1, 65535));
        end
        foreach (slot_loaded[i])
            slot_loaded[i] = 1'b0;

        // Hold every input at a known value while reset is applied
        rst_n               <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= REG_MIN_TONE_FREQ;
        cfg_data            <= 16'd0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.command     <= CMD_BEGIN;
        cmd_bus.note_slot   <= 4'd0;
        cmd_bus.note_freq   <= 16'd0;
        cmd_bus.note_length <= 16'd0;
        cmd_bus.note_count  <= 8'd0;
        cmd_bus.now_ms      <= 32'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset configuration, with light idling
        sender_idle_pct = 25;
        foreach (opening_rows[i])
            push_request(opening_rows[i].req, opening_rows[i].typed, opening_rows[i].want);

        // Random phases; reprogram all registers only once the block is idle
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_sounds();
            write_register(REG_MIN_TONE_FREQ,      phase_regs[ph][0]);
            write_register(REG_ACK_FREQ,           phase_regs[ph][1]);
            write_register(REG_ACK_LENGTH_MS,      phase_regs[ph][2]);
            write_register(REG_SELFTEST_LENGTH_MS, phase_regs[ph][3]);
            cfg_write_en <= 1'b0;
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Vary the request gap density in stretches, some with none
                if (k % 40 == 0)
                    sender_idle_pct = ($urandom_range(0, 2) == 0) ? 0
                                    : ($urandom_range(0, 1) ? 20 : 60);
                if (ph == PHASES - 1 && k >= PHASE_ITEMS - TAIL_ITEMS)
                    quiet_tail = 1'b1;
                push_request(make_request(), 1'b0, UNTYPED);
            end
        end

        // Wait out the last sounds plus the SETTLE margin for anything stray
        drain_sounds();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/msq_pkg.sv
hdl/msq_if.sv
hdl/msq_front.sv
hdl/msq_queue.sv
hdl/msq_back.sv
hdl/melody_note_sequencer_top.sv
bench/melody_note_sequencer_top_tb.sv
